[hw/rtl/assert_macros.svh]
// assertion macros for the checker file
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define V2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define V2_NEVER(label, cond, msg) \
    `V2_ASSERT(label, !(cond), msg)

`endif

[hw/rtl/v2alu_pkg.sv]
// shared constants, types and helpers of the 2d vector unit
// no dependencies
package v2alu_pkg;

    localparam logic [3:0] FUNC_ADD   = 4'd0;
    localparam logic [3:0] FUNC_SUB   = 4'd1;
    localparam logic [3:0] FUNC_SCALE = 4'd2;
    localparam logic [3:0] FUNC_DIV   = 4'd3;
    localparam logic [3:0] FUNC_LEN   = 4'd4;
    localparam logic [3:0] FUNC_DOT   = 4'd5;
    localparam logic [3:0] FUNC_CROSS = 4'd6;
    localparam logic [3:0] FUNC_NORM  = 4'd7;
    localparam logic [3:0] FUNC_ROT   = 4'd8;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_ERR = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_W        = 48;
    localparam int DIV_STEPS    = DIV_W;
    localparam int DVS_W        = 33;

    // register stage that feeds the output register (input register is stage 0)
    localparam int FINAL_STAGE = 3 + SQRT_STEPS + DIV_STEPS;
    localparam int ROT_LATENCY = CORDIC_STEPS + 3;
    localparam int ROT_PAD     = FINAL_STAGE - ROT_LATENCY;
    // edges from request accept to the edge that takes the result
    localparam int LATENCY     = FINAL_STAGE + 2;

    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [31:0] PI_Q16      = 32'sd205887;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] sc;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic [31:0]        rs;
        logic               sat;
        logic               err;
        logic               neg_x;
        logic               neg_y;
    } t_item;

    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat r;
        if (v > 66'sd2147483647) begin
            r = '{sat: 1'b1, val: 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            r = '{sat: 1'b1, val: 32'h8000_0000};
        end else begin
            r = '{sat: 1'b0, val: v[31:0]};
        end
        return r;
    endfunction

    // atan(2^-k) in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'h3243F6A8;
            5'd1:    a = 32'h1DAC6705;
            5'd2:    a = 32'h0FADBAFC;
            5'd3:    a = 32'h07F56EA6;
            5'd4:    a = 32'h03FEAB76;
            5'd5:    a = 32'h01FFD55B;
            5'd6:    a = 32'h00FFFAAA;
            5'd7:    a = 32'h007FFF55;
            5'd8:    a = 32'h003FFFEA;
            5'd9:    a = 32'h001FFFFD;
            5'd10:   a = 32'h000FFFFF;
            5'd11:   a = 32'h0007FFFF;
            5'd12:   a = 32'h0003FFFF;
            5'd13:   a = 32'h0001FFFF;
            5'd14:   a = 32'h0000FFFF;
            5'd15:   a = 32'h00007FFF;
            5'd16:   a = 32'h00003FFF;
            5'd17:   a = 32'h00001FFF;
            5'd18:   a = 32'h00000FFF;
            5'd19:   a = 32'h000007FF;
            5'd20:   a = 32'h000003FF;
            5'd21:   a = 32'h000001FF;
            5'd22:   a = 32'h000000FF;
            5'd23:   a = 32'h0000007F;
            5'd24:   a = 32'h0000003F;
            5'd25:   a = 32'h0000001F;
            5'd26:   a = 32'h0000000F;
            5'd27:   a = 32'h00000008;
            5'd28:   a = 32'h00000004;
            5'd29:   a = 32'h00000002;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

[hw/rtl/vec2_fixed_point_alu.sv]
// 2d vector unit in signed Q16.16: add, sub, scale, divide, length, dot, cross,
// normalize and rotate; depends on v2alu_pkg, v2alu_cordic and v2alu_div.
// A request is taken on every clock edge that sees start high; busy is tied low,
// so requests can follow back to back with no gaps. Every operation passes
// through the same registers (input register, product and rounding stages,
// the 32-stage square root, a divider setup stage, the 48-stage divider and
// the output register) from request to result, so results leave in request
// order. This depth is set by the normalize path, which runs the square root
// and then the divider. Each result is shown for exactly one cycle with
// o_done high and must be taken in that cycle.
module vec2_fixed_point_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_scalar_in,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y,
    output logic signed [31:0] o_result_scalar,
    output logic [1:0]         o_status,
    output logic               o_done
);

    assign busy = 1'b0;

    // stage 0: input register
    logic               r0_valid;
    logic [3:0]         r0_func;
    logic signed [31:0] r0_ax, r0_ay, r0_bx, r0_by, r0_sc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_func <= i_func;
        r0_ax   <= i_first_x;
        r0_ay   <= i_first_y;
        r0_bx   <= i_second_x;
        r0_by   <= i_second_y;
        r0_sc   <= i_scalar_in;
    end

    // stage 1: products, add and subtract
    logic signed [31:0] m1a, m1b, m2a, m2b;
    logic signed [32:0] sum_x, sum_y;
    v2alu_pkg::t_sat    s1x, s1y;
    v2alu_pkg::t_item   n1_item, r1_item;
    logic signed [63:0] r1_p1, r1_p2;
    logic               r1_valid;

    always_comb begin
        m1a = r0_ax;
        m1b = r0_sc;
        m2a = r0_ay;
        m2b = r0_sc;
        case (r0_func)
            v2alu_pkg::FUNC_DOT: begin
                m1b = r0_bx;
                m2b = r0_by;
            end
            v2alu_pkg::FUNC_CROSS: begin
                m1b = r0_by;
                m2b = r0_bx;
            end
            v2alu_pkg::FUNC_LEN, v2alu_pkg::FUNC_NORM: begin
                m1b = r0_ax;
                m2b = r0_ay;
            end
            default: begin
                m1b = r0_sc;
                m2b = r0_sc;
            end
        endcase

        if (r0_func == v2alu_pkg::FUNC_SUB) begin
            sum_x = 33'(r0_ax) - 33'(r0_bx);
            sum_y = 33'(r0_ay) - 33'(r0_by);
        end else begin
            sum_x = 33'(r0_ax) + 33'(r0_bx);
            sum_y = 33'(r0_ay) + 33'(r0_by);
        end
        s1x = v2alu_pkg::sat32(66'(sum_x));
        s1y = v2alu_pkg::sat32(66'(sum_y));

        n1_item      = '0;
        n1_item.func = r0_func;
        n1_item.ax   = r0_ax;
        n1_item.ay   = r0_ay;
        n1_item.sc   = r0_sc;
        if (r0_func == v2alu_pkg::FUNC_ADD || r0_func == v2alu_pkg::FUNC_SUB) begin
            n1_item.rx  = s1x.val;
            n1_item.ry  = s1y.val;
            n1_item.sat = s1x.sat | s1y.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_item <= n1_item;
        r1_p1   <= m1a * m1b;
        r1_p2   <= m2a * m2b;
    end

    // rotate lane runs beside the main pipe and is padded to the final stage
    logic [31:0] rot_rx, rot_ry;
    logic        rot_sat;

    v2alu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_angle (r0_sc),
        .i_ax    (r0_ax),
        .i_ay    (r0_ay),
        .o_rx    (rot_rx),
        .o_ry    (rot_ry),
        .o_sat   (rot_sat)
    );

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic        sat;
    } t_rot;

    t_rot r_pad [v2alu_pkg::ROT_PAD];

    always_ff @(posedge i_clk) begin
        r_pad[0] <= '{rx: rot_rx, ry: rot_ry, sat: rot_sat};
    end

    for (genvar gi = 1; gi < v2alu_pkg::ROT_PAD; gi++) begin : g_pad
        always_ff @(posedge i_clk) begin
            r_pad[gi] <= r_pad[gi-1];
        end
    end

    // stage 2: rounding of scale, dot and cross; radicand for the root
    logic signed [65:0] v_px, v_py, v_ps;
    v2alu_pkg::t_sat    s2x, s2y, s2s;
    v2alu_pkg::t_item   n2_item, r2_item;
    logic [63:0]        r2_rad;
    logic               r2_valid;

    always_comb begin
        v_px = (66'(r1_p1) + 66'sd32768) >>> 16;
        v_py = (66'(r1_p2) + 66'sd32768) >>> 16;
        if (r1_item.func == v2alu_pkg::FUNC_CROSS) begin
            v_ps = (66'(r1_p1) - 66'(r1_p2) + 66'sd32768) >>> 16;
        end else begin
            v_ps = (66'(r1_p1) + 66'(r1_p2) + 66'sd32768) >>> 16;
        end
        s2x = v2alu_pkg::sat32(v_px);
        s2y = v2alu_pkg::sat32(v_py);
        s2s = v2alu_pkg::sat32(v_ps);

        n2_item = r1_item;
        case (r1_item.func)
            v2alu_pkg::FUNC_SCALE: begin
                n2_item.rx  = s2x.val;
                n2_item.ry  = s2y.val;
                n2_item.sat = s2x.sat | s2y.sat;
            end
            v2alu_pkg::FUNC_DOT, v2alu_pkg::FUNC_CROSS: begin
                n2_item.rs  = s2s.val;
                n2_item.sat = s2s.sat;
            end
            default: begin
                n2_item = r1_item;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_item <= n2_item;
        r2_rad  <= 64'(r1_p1) + 64'(r1_p2);
    end

    // digit-by-digit square root, one result bit a stage
    typedef struct packed {
        v2alu_pkg::t_item item;
        logic [63:0]      n;
        logic [63:0]      res;
    } t_sq;

    t_sq                              r_sq       [v2alu_pkg::SQRT_STEPS];
    logic [v2alu_pkg::SQRT_STEPS-1:0] r_sq_valid;

    for (genvar gi = 0; gi < v2alu_pkg::SQRT_STEPS; gi++) begin : g_sqrt
        t_sq         src, n_step;
        logic        src_valid;
        logic [63:0] sq_bit, trial;

        if (gi == 0) begin : g_first
            assign src       = '{item: r2_item, n: r2_rad, res: 64'd0};
            assign src_valid = r2_valid;
        end else begin : g_rest
            assign src       = r_sq[gi-1];
            assign src_valid = r_sq_valid[gi-1];
        end

        always_comb begin
            sq_bit = 64'd1 << (62 - 2 * gi);
            trial  = src.res + sq_bit;
            n_step = src;
            if (src.n >= trial) begin
                n_step.n   = src.n - trial;
                n_step.res = (src.res >> 1) + sq_bit;
            end else begin
                n_step.res = src.res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[gi] <= 1'b0;
            end else begin
                r_sq_valid[gi] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq[gi] <= n_step;
        end
    end

    // divider setup: operand magnitudes, signs, length result, zero checks
    t_sq                           sq_last;
    logic [32:0]                   len;
    logic                          neg_d;
    logic signed [32:0]            ax_ext, ay_ext, ax_abs, ay_abs;
    v2alu_pkg::t_sat               s3l;
    v2alu_pkg::t_item              n3_item, r3_item;
    logic [v2alu_pkg::DVS_W-1:0]   n3_dvs, r3_dvs;
    logic [v2alu_pkg::DIV_W-1:0]   r3_dvd_x, r3_dvd_y;
    logic                          r3_valid;

    always_comb begin
        sq_last = r_sq[v2alu_pkg::SQRT_STEPS-1];
        len     = sq_last.res[32:0];
        ax_ext  = 33'(sq_last.item.ax);
        ay_ext  = 33'(sq_last.item.ay);
        ax_abs  = ax_ext[32] ? -ax_ext : ax_ext;
        ay_abs  = ay_ext[32] ? -ay_ext : ay_ext;
        s3l     = v2alu_pkg::sat32(66'({1'b0, len}));
        n3_item = sq_last.item;
        n3_dvs  = len;
        neg_d   = 1'b0;
        case (sq_last.item.func)
            v2alu_pkg::FUNC_LEN: begin
                n3_item.rs  = s3l.val;
                n3_item.sat = s3l.sat;
            end
            v2alu_pkg::FUNC_DIV: begin
                neg_d       = sq_last.item.sc[31];
                n3_dvs      = 33'(sq_last.item.sc[31] ? -33'(sq_last.item.sc)
                                                      : 33'(sq_last.item.sc));
                n3_item.err = (sq_last.item.sc == 32'sd0);
            end
            v2alu_pkg::FUNC_NORM: begin
                n3_item.err = (len == 33'd0);
            end
            default: begin
                n3_dvs = len;
            end
        endcase
        n3_item.neg_x = sq_last.item.ax[31] ^ neg_d;
        n3_item.neg_y = sq_last.item.ay[31] ^ neg_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r_sq_valid[v2alu_pkg::SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_item  <= n3_item;
        r3_dvs   <= n3_dvs;
        r3_dvd_x <= {ax_abs[31:0], 16'h0000};
        r3_dvd_y <= {ay_abs[31:0], 16'h0000};
    end

    logic                          dv_valid;
    v2alu_pkg::t_item              dv_item;
    logic [v2alu_pkg::DIV_W-1:0]   quo_x, quo_y;

    v2alu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_item  (r3_item),
        .i_dvd_x (r3_dvd_x),
        .i_dvd_y (r3_dvd_y),
        .i_dvs   (r3_dvs),
        .o_valid (dv_valid),
        .o_item  (dv_item),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y)
    );

    // result select
    logic signed [65:0] qv_x, qv_y;
    v2alu_pkg::t_sat    sqx, sqy;
    t_rot               rot_d;
    logic [31:0]        n_rx, n_ry, n_rs;
    logic               n_sat, n_err;
    logic [1:0]         n_status;
    logic [31:0]        r_out_x, r_out_y, r_out_s;
    logic [1:0]         r_out_status;
    logic               r_out_valid;

    always_comb begin
        qv_x  = dv_item.neg_x ? -66'(quo_x) : 66'(quo_x);
        qv_y  = dv_item.neg_y ? -66'(quo_y) : 66'(quo_y);
        sqx   = v2alu_pkg::sat32(qv_x);
        sqy   = v2alu_pkg::sat32(qv_y);
        rot_d = r_pad[v2alu_pkg::ROT_PAD-1];
        n_rx  = '0;
        n_ry  = '0;
        n_rs  = '0;
        n_sat = 1'b0;
        n_err = 1'b0;
        case (dv_item.func)
            v2alu_pkg::FUNC_ADD, v2alu_pkg::FUNC_SUB, v2alu_pkg::FUNC_SCALE,
            v2alu_pkg::FUNC_LEN, v2alu_pkg::FUNC_DOT, v2alu_pkg::FUNC_CROSS: begin
                n_rx  = dv_item.rx;
                n_ry  = dv_item.ry;
                n_rs  = dv_item.rs;
                n_sat = dv_item.sat;
            end
            v2alu_pkg::FUNC_DIV, v2alu_pkg::FUNC_NORM: begin
                if (dv_item.err) begin
                    n_err = 1'b1;
                end else begin
                    n_rx  = sqx.val;
                    n_ry  = sqy.val;
                    n_sat = sqx.sat | sqy.sat;
                end
            end
            v2alu_pkg::FUNC_ROT: begin
                n_rx  = rot_d.rx;
                n_ry  = rot_d.ry;
                n_sat = rot_d.sat;
            end
            default: begin
                n_rx = '0;
            end
        endcase
        if (n_err) begin
            n_status = v2alu_pkg::STAT_ERR;
        end else if (n_sat) begin
            n_status = v2alu_pkg::STAT_SAT;
        end else begin
            n_status = v2alu_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x      <= n_rx;
        r_out_y      <= n_ry;
        r_out_s      <= n_rs;
        r_out_status <= n_status;
    end

    assign o_done          = r_out_valid;
    assign o_result_x      = r_out_x;
    assign o_result_y      = r_out_y;
    assign o_result_scalar = r_out_s;
    assign o_status        = r_out_status;

endmodule

[hw/rtl/v2alu_cordic.sv]
// rotate lane: angle clamp and reduction, pipelined cordic, rotation products
// depends on v2alu_pkg
module v2alu_cordic (
    input  logic               i_clk,
    input  logic signed [31:0] i_angle,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    output logic [31:0]        o_rx,
    output logic [31:0]        o_ry,
    output logic               o_sat
);

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
        logic               asat;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
    } t_lane;

    t_lane r_st [v2alu_pkg::CORDIC_STEPS+1];
    t_lane n_st0;

    logic signed [31:0] a_cl;
    logic signed [33:0] z_raw;

    always_comb begin
        n_st0 = '0;
        a_cl  = i_angle;
        if (i_angle > v2alu_pkg::PI_Q16) begin
            a_cl       = v2alu_pkg::PI_Q16;
            n_st0.asat = 1'b1;
        end else if (i_angle < -v2alu_pkg::PI_Q16) begin
            a_cl       = -v2alu_pkg::PI_Q16;
            n_st0.asat = 1'b1;
        end
        z_raw   = 34'(a_cl) <<< 14;
        n_st0.z = z_raw;
        // fold into -pi/2..pi/2, negate sin and cos later
        if (z_raw > v2alu_pkg::HALF_PI_Q30) begin
            n_st0.z    = z_raw - v2alu_pkg::PI_Q30;
            n_st0.flip = 1'b1;
        end else if (z_raw < -v2alu_pkg::HALF_PI_Q30) begin
            n_st0.z    = z_raw + v2alu_pkg::PI_Q30;
            n_st0.flip = 1'b1;
        end
        n_st0.x  = v2alu_pkg::GAIN_Q30;
        n_st0.y  = '0;
        n_st0.ax = i_ax;
        n_st0.ay = i_ay;
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
    end

    for (genvar gi = 0; gi < v2alu_pkg::CORDIC_STEPS; gi++) begin : g_step
        t_lane              n_step;
        logic signed [33:0] dx, dy, da;
        always_comb begin
            dx     = r_st[gi].y >>> gi;
            dy     = r_st[gi].x >>> gi;
            da     = $signed({2'b00, v2alu_pkg::atan_q30(5'(gi))});
            n_step = r_st[gi];
            if (!r_st[gi].z[33]) begin
                n_step.x = r_st[gi].x - dx;
                n_step.y = r_st[gi].y + dy;
                n_step.z = r_st[gi].z - da;
            end else begin
                n_step.x = r_st[gi].x + dx;
                n_step.y = r_st[gi].y - dy;
                n_step.z = r_st[gi].z + da;
            end
        end
        always_ff @(posedge i_clk) begin
            r_st[gi+1] <= n_step;
        end
    end

    t_lane              last;
    logic signed [33:0] cval, sval;
    logic signed [65:0] r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic               r_m_asat;

    assign last = r_st[v2alu_pkg::CORDIC_STEPS];
    assign cval = last.flip ? -last.x : last.x;
    assign sval = last.flip ? -last.y : last.y;

    always_ff @(posedge i_clk) begin
        r_p_xc   <= last.ax * cval;
        r_p_ys   <= last.ay * sval;
        r_p_xs   <= last.ax * sval;
        r_p_yc   <= last.ay * cval;
        r_m_asat <= last.asat;
    end

    // Q20.46 back to Q16.16, round half up
    logic signed [65:0] vx, vy;
    v2alu_pkg::t_sat    sx, sy;
    logic [31:0]        r_rx, r_ry;
    logic               r_sat;

    assign vx = (r_p_xc - r_p_ys + 66'sd536870912) >>> 30;
    assign vy = (r_p_xs + r_p_yc + 66'sd536870912) >>> 30;
    assign sx = v2alu_pkg::sat32(vx);
    assign sy = v2alu_pkg::sat32(vy);

    always_ff @(posedge i_clk) begin
        r_rx  <= sx.val;
        r_ry  <= sy.val;
        r_sat <= sx.sat | sy.sat | r_m_asat;
    end

    assign o_rx  = r_rx;
    assign o_ry  = r_ry;
    assign o_sat = r_sat;

endmodule

[hw/rtl/v2alu_div.sv]
// pipelined restoring divider for both vector components, one quotient bit a stage
// depends on v2alu_pkg
module v2alu_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  v2alu_pkg::t_item                 i_item,
    input  logic [v2alu_pkg::DIV_W-1:0]      i_dvd_x,
    input  logic [v2alu_pkg::DIV_W-1:0]      i_dvd_y,
    input  logic [v2alu_pkg::DVS_W-1:0]      i_dvs,
    output logic                             o_valid,
    output v2alu_pkg::t_item                 o_item,
    output logic [v2alu_pkg::DIV_W-1:0]      o_quo_x,
    output logic [v2alu_pkg::DIV_W-1:0]      o_quo_y
);

    typedef struct packed {
        v2alu_pkg::t_item                item;
        logic [v2alu_pkg::DVS_W-1:0]     rem_x;
        logic [v2alu_pkg::DVS_W-1:0]     rem_y;
        logic [v2alu_pkg::DIV_W-1:0]     w_x;
        logic [v2alu_pkg::DIV_W-1:0]     w_y;
        logic [v2alu_pkg::DVS_W-1:0]     dvs;
    } t_div;

    t_div                              st_in;
    t_div                              r_st    [v2alu_pkg::DIV_STEPS];
    logic [v2alu_pkg::DIV_STEPS-1:0]   r_valid;

    always_comb begin
        st_in       = '0;
        st_in.item  = i_item;
        st_in.w_x   = i_dvd_x;
        st_in.w_y   = i_dvd_y;
        st_in.dvs   = i_dvs;
    end

    for (genvar gi = 0; gi < v2alu_pkg::DIV_STEPS; gi++) begin : g_step
        t_div                          src, n_step;
        logic                          src_valid;
        logic [v2alu_pkg::DVS_W:0]     tx, ty;

        if (gi == 0) begin : g_first
            assign src       = st_in;
            assign src_valid = i_valid;
        end else begin : g_rest
            assign src       = r_st[gi-1];
            assign src_valid = r_valid[gi-1];
        end

        always_comb begin
            tx     = {src.rem_x, src.w_x[v2alu_pkg::DIV_W-1]};
            ty     = {src.rem_y, src.w_y[v2alu_pkg::DIV_W-1]};
            n_step = src;
            if (tx >= {1'b0, src.dvs}) begin
                n_step.rem_x = v2alu_pkg::DVS_W'(tx - {1'b0, src.dvs});
                n_step.w_x   = {src.w_x[v2alu_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_step.rem_x = tx[v2alu_pkg::DVS_W-1:0];
                n_step.w_x   = {src.w_x[v2alu_pkg::DIV_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, src.dvs}) begin
                n_step.rem_y = v2alu_pkg::DVS_W'(ty - {1'b0, src.dvs});
                n_step.w_y   = {src.w_y[v2alu_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_step.rem_y = ty[v2alu_pkg::DVS_W-1:0];
                n_step.w_y   = {src.w_y[v2alu_pkg::DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[gi] <= 1'b0;
            end else begin
                r_valid[gi] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[gi] <= n_step;
        end
    end

    assign o_valid = r_valid[v2alu_pkg::DIV_STEPS-1];
    assign o_item  = r_st[v2alu_pkg::DIV_STEPS-1].item;
    assign o_quo_x = r_st[v2alu_pkg::DIV_STEPS-1].w_x;
    assign o_quo_y = r_st[v2alu_pkg::DIV_STEPS-1].w_y;

endmodule

[hw/rtl/v2alu_checker.sv]
// port-level checks of the 2d vector unit, bound to the top level
// depends on v2alu_pkg and assert_macros.svh
`include "assert_macros.svh"

module v2alu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [3:0]  i_func,
    input logic [31:0] o_result_x,
    input logic [31:0] o_result_y,
    input logic [31:0] o_result_scalar,
    input logic [1:0]  o_status,
    input logic        o_done
);

    `V2_NEVER(a_status_code, o_done && o_status != v2alu_pkg::STAT_OK && o_status != v2alu_pkg::STAT_ERR && o_status != v2alu_pkg::STAT_SAT, "undefined status code")

    `V2_ASSERT(a_err_zero, (o_done && o_status == v2alu_pkg::STAT_ERR) |-> (o_result_x == 32'd0 && o_result_y == 32'd0 && o_result_scalar == 32'd0), "error result not zeroed")

    `V2_ASSERT(a_latency, o_done |-> $past(start && !busy, v2alu_pkg::LATENCY), "result without a request")

    `V2_ASSERT(a_err_func, (o_done && o_status == v2alu_pkg::STAT_ERR) |-> ($past(i_func, v2alu_pkg::LATENCY) == v2alu_pkg::FUNC_DIV || $past(i_func, v2alu_pkg::LATENCY) == v2alu_pkg::FUNC_NORM), "error on operation that cannot fail")

endmodule

bind vec2_fixed_point_alu v2alu_checker u_checker (.*);
